// ----- hdl/mcpg_pkg.sv -----
// Package for the monochrome cell pixel generator.
// Holds shared constants, register indexes and beat layout widths.
// No dependencies.
package mcpg_pkg;

    localparam int ROWS_PER_CHAR = 14;
    localparam int FONT_DEPTH    = 4096;

    localparam int FONT_W  = 8;
    localparam int CODE_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int FADDR_W = 12;
    localparam int CBITS_W = 9;
    localparam int WORD_W  = 16;
    localparam int PIX_W   = 16;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 5;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    localparam logic [1:0] REG_GRAPHICS_MODE  = 2'd0;
    localparam logic [1:0] REG_DISPLAY_ENABLE = 2'd1;
    localparam logic [1:0] REG_BLINK_ENABLE   = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [CODE_W-1:0] CLONE_MASK  = 8'he0;
    localparam logic [CODE_W-1:0] CLONE_CODES = 8'hc0;
    localparam logic [ATTR_W-1:0] REV_MASK    = 8'h77;
    localparam logic [ATTR_W-1:0] REV_VALUE   = 8'h70;
    localparam logic [ATTR_W-1:0] FG_MASK     = 8'h0f;
    localparam logic [2:0]        UL_ATTR     = 3'b001;
    localparam logic [ROW_W-1:0]  UL_ROW      = 5'd13;
    localparam logic [CBITS_W-1:0] SOLID_ROW  = 9'h1ff;

    localparam logic [IDX_W-1:0] FG_GRAPHICS = 5'd16;
    localparam logic [IDX_W-1:0] BG_REVERSE  = 5'd7;
    localparam logic [IDX_W-1:0] BG_BRIGHT   = 5'd15;
    localparam logic [CNT_W-1:0] COUNT_TEXT  = 5'd9;
    localparam logic [CNT_W-1:0] COUNT_GRAPH = 5'd16;

endpackage

// ----- hdl/monochrome_cell_pixel_generator_core.sv -----
// Top level of the monochrome cell pixel generator: font store, render pipeline, output beat.
// Depends on mcpg_pkg and mcpg_ram.
//
// One input beat is taken per clock while s_tready is high. A render beat gives one output
// beat: the font read and the cell are registered in s1, then pixel and palette logic feeds
// the output register. A load beat writes the font memory and gives no output beat. After
// reset the font memory is cleared one entry per cycle over all FONT_DEPTH entries (4096 by
// default); s_tready stays low during that pass while configuration writes are still taken.
// Configuration must be written only while idle; the block itself does not enforce this.
module monochrome_cell_pixel_generator_core #(
    parameter int FONT_DEPTH = mcpg_pkg::FONT_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic                             cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // font_address[11:0], font_data[19:12], char_code[27:20], attr_byte[35:28],
    // row_in_cell[40:36], cursor_here[41], cursor_bits[50:42], blink_phase[51],
    // pixel_word[67:52], zeros[71:68]
    input  logic [mcpg_pkg::IN_DATA_W-1:0]   s_tdata,
    // operation[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_bits[15:0], pixel_count[20:16], fg_index[25:21], bg_index[30:26], zero[31]
    output logic [mcpg_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(FONT_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FONT_DEPTH - 1);

    typedef struct packed {
        logic [mcpg_pkg::CODE_W-1:0]  char_code;
        logic [mcpg_pkg::ATTR_W-1:0]  attr_byte;
        logic [mcpg_pkg::ROW_W-1:0]   row_in_cell;
        logic                         cursor_here;
        logic [mcpg_pkg::CBITS_W-1:0] cursor_bits;
        logic                         blink_phase;
        logic [mcpg_pkg::WORD_W-1:0]  pixel_word;
    } cell_t;

    logic                          graphics_mode_reg, graphics_mode_next;
    logic                          display_enable_reg, display_enable_next;
    logic                          blink_enable_reg, blink_enable_next;
    logic                          clearing_reg, clearing_next;
    logic [AW-1:0]                 clr_addr_reg, clr_addr_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          out_valid_reg, out_valid_next;
    cell_t                         s1_cell_reg;
    logic [mcpg_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [mcpg_pkg::FADDR_W-1:0]  in_font_address;
    logic [mcpg_pkg::FONT_W-1:0]   in_font_data;
    cell_t                         in_cell;
    logic                          s1_adv;
    logic                          accept;
    logic                          is_render;
    logic [mcpg_pkg::FADDR_W-1:0]  rend_addr;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [mcpg_pkg::FONT_W-1:0]   ram_wdata;
    logic [mcpg_pkg::FONT_W-1:0]   font_row;

    logic [mcpg_pkg::CBITS_W-1:0]  text_bits;
    logic [mcpg_pkg::PIX_W-1:0]    pix_bits;
    logic [mcpg_pkg::CNT_W-1:0]    pix_count;
    logic [mcpg_pkg::IDX_W-1:0]    fg_idx;
    logic [mcpg_pkg::IDX_W-1:0]    bg_idx;

    assign in_font_address         = s_tdata[11:0];
    assign in_font_data            = s_tdata[19:12];
    assign in_cell.char_code       = s_tdata[27:20];
    assign in_cell.attr_byte       = s_tdata[35:28];
    assign in_cell.row_in_cell     = s_tdata[40:36];
    assign in_cell.cursor_here     = s_tdata[41];
    assign in_cell.cursor_bits     = s_tdata[50:42];
    assign in_cell.blink_phase     = s_tdata[51];
    assign in_cell.pixel_word      = s_tdata[67:52];

    assign s1_adv    = !out_valid_reg || m_tready;
    assign s_tready  = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept    = s_tvalid && s_tready;
    assign is_render = (s_tuser == mcpg_pkg::OP_RENDER);

    assign rend_addr = mcpg_pkg::FADDR_W'(mcpg_pkg::ROWS_PER_CHAR)
                       * {4'b0000, in_cell.char_code}
                       + {8'b0000_0000, in_cell.row_in_cell[3:0]};

    assign ram_we    = clearing_reg || (accept && !is_render);
    assign ram_waddr = clearing_reg ? clr_addr_reg : AW'(in_font_address);
    assign ram_wdata = clearing_reg ? '0 : in_font_data;

    mcpg_ram #(
        .WIDTH (mcpg_pkg::FONT_W),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept && is_render),
        .raddr (AW'(rend_addr)),
        .rdata (font_row)
    );

    always_comb
    begin
        text_bits = {font_row, 1'b0};
        if ((s1_cell_reg.char_code & mcpg_pkg::CLONE_MASK) == mcpg_pkg::CLONE_CODES)
        begin
            text_bits[0] = font_row[0];
        end
        if (s1_cell_reg.attr_byte[2:0] == mcpg_pkg::UL_ATTR
            && s1_cell_reg.row_in_cell == mcpg_pkg::UL_ROW)
        begin
            text_bits = mcpg_pkg::SOLID_ROW;
        end
        if (s1_cell_reg.attr_byte[7] && blink_enable_reg && !s1_cell_reg.blink_phase)
        begin
            text_bits = '0;
        end
        if (s1_cell_reg.cursor_here && s1_cell_reg.blink_phase)
        begin
            text_bits = text_bits | s1_cell_reg.cursor_bits;
        end

        pix_count = graphics_mode_reg ? mcpg_pkg::COUNT_GRAPH : mcpg_pkg::COUNT_TEXT;

        priority if (!display_enable_reg)
        begin
            pix_bits = '0;
            fg_idx   = '0;
            bg_idx   = '0;
        end
        else if (graphics_mode_reg)
        begin
            pix_bits = s1_cell_reg.pixel_word;
            fg_idx   = mcpg_pkg::FG_GRAPHICS;
            bg_idx   = '0;
        end
        else if ((s1_cell_reg.attr_byte & mcpg_pkg::REV_MASK) == mcpg_pkg::REV_VALUE)
        begin
            pix_bits = mcpg_pkg::PIX_W'(text_bits);
            fg_idx   = '0;
            bg_idx   = (s1_cell_reg.attr_byte[7] && !blink_enable_reg)
                       ? mcpg_pkg::BG_BRIGHT : mcpg_pkg::BG_REVERSE;
        end
        else
        begin
            pix_bits = mcpg_pkg::PIX_W'(text_bits);
            fg_idx   = mcpg_pkg::IDX_W'(s1_cell_reg.attr_byte & mcpg_pkg::FG_MASK);
            bg_idx   = '0;
        end
    end

    always_comb
    begin
        graphics_mode_next  = graphics_mode_reg;
        display_enable_next = display_enable_reg;
        blink_enable_next   = blink_enable_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mcpg_pkg::REG_GRAPHICS_MODE:  graphics_mode_next  = cfg_data;
                mcpg_pkg::REG_DISPLAY_ENABLE: display_enable_next = cfg_data;
                mcpg_pkg::REG_BLINK_ENABLE:   blink_enable_next   = cfg_data;
                default: ;
            endcase
        end

        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (!s1_valid_reg || s1_adv)
        begin
            s1_valid_next = accept && is_render;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graphics_mode_reg  <= 1'b0;
            display_enable_reg <= 1'b0;
            blink_enable_reg   <= 1'b0;
            clearing_reg       <= 1'b1;
            clr_addr_reg       <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            graphics_mode_reg  <= graphics_mode_next;
            display_enable_reg <= display_enable_next;
            blink_enable_reg   <= blink_enable_next;
            clearing_reg       <= clearing_next;
            clr_addr_reg       <= clr_addr_next;
            s1_valid_reg       <= s1_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_render)
        begin
            s1_cell_reg <= in_cell;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= {1'b0, bg_idx, fg_idx, pix_count, pix_bits};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hdl/mcpg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth set by parameters; no dependencies.
module mcpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
